// ----- rtl/upd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// upd_pkg
// Types, constants and helpers shared by the percent-decoder modules.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [4:0] NOT_HEX  = 5'd16;

    // Escape phase of the front end; the two-bit code for 3 is never entered.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // Up to three result bytes released by one input item.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] cnt;
        logic       text_end;
    } t_job;

    // Nibble value of a hex digit, NOT_HEX when the byte is not one.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = NOT_HEX;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            v = {1'b0, b[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/upd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// upd_front
// Tracks the escape phase and turns each accepted byte into a job of
// zero to three result bytes.
// ----------------------------------------------------------------------------
module upd_front
    import upd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output t_job            o_job,
    output logic            o_job_valid,
    output t_phase          o_phase
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_held;
    logic [7:0] n_held;
    logic [4:0] in_hex;
    logic [4:0] held_hex;
    logic       in_is_hex;
    logic       in_is_pct;

    assign in_hex    = hex_value(i_in_byte);
    assign held_hex  = hex_value(r_held);
    assign in_is_hex = (in_hex != NOT_HEX);
    assign in_is_pct = (i_in_byte == PCT_CHAR);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        if (i_accept) begin
            case (r_phase)
                PH_PCT: begin
                    if (in_is_hex) begin
                        n_phase = PH_DIGIT;
                        n_held  = i_in_byte;
                    end else begin
                        n_phase = in_is_pct ? PH_PCT : PH_IDLE;
                    end
                end
                PH_DIGIT: begin
                    if (in_is_hex) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = in_is_pct ? PH_PCT : PH_IDLE;
                    end
                end
                default: begin
                    n_phase = in_is_pct ? PH_PCT : PH_IDLE;
                end
            endcase
            // flush at end of text
            if (i_in_last) begin
                n_phase = PH_IDLE;
            end
        end
    end

    // Job contents
    always_comb begin
        o_job          = '0;
        o_job.text_end = i_in_last;
        case (r_phase)
            PH_PCT: begin
                o_job.byte0 = PCT_CHAR;
                if (in_is_hex) begin
                    o_job.byte1 = i_in_byte;
                    o_job.cnt   = i_in_last ? 2'd2 : 2'd0;
                end else begin
                    o_job.byte1 = in_is_pct ? PCT_CHAR : i_in_byte;
                    o_job.cnt   = (in_is_pct && !i_in_last) ? 2'd1 : 2'd2;
                end
            end
            PH_DIGIT: begin
                if (in_is_hex) begin
                    o_job.byte0 = {held_hex[3:0], in_hex[3:0]};
                    o_job.cnt   = 2'd1;
                end else begin
                    o_job.byte0 = PCT_CHAR;
                    o_job.byte1 = r_held;
                    o_job.byte2 = in_is_pct ? PCT_CHAR : i_in_byte;
                    o_job.cnt   = (in_is_pct && !i_in_last) ? 2'd2 : 2'd3;
                end
            end
            default: begin
                o_job.byte0 = i_in_byte;
                o_job.cnt   = (in_is_pct && !i_in_last) ? 2'd0 : 2'd1;
            end
        endcase
    end

    // drop jobs that release nothing
    assign o_job_valid = i_accept && (o_job.cnt != 2'd0);
    assign o_phase     = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/upd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// upd_queue
// Short job queue between the front end and the byte serializer.
// ----------------------------------------------------------------------------
module upd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr,
    input  wire t_job                       i_wr_job,
    input  wire logic                       i_rd,
    output t_job                            o_rd_job,
    output logic                            o_empty,
    output logic                            o_full,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_wr;
    logic          do_rd;

    assign o_empty  = (r_count == '0);
    assign o_full   = (r_count == FULL_CNT);
    assign o_count  = r_count;
    assign o_rd_job = r_mem[r_rd_ptr];
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/upd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// upd_back
// Serializes the head job one byte per cycle into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
module upd_back
    import upd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_job       i_job,
    input  wire logic       i_job_empty,
    output logic            o_job_rd,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_out_run_last,
    output logic            o_out_text_end
);

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_text_end;
    logic       load;
    logic       take;
    logic       is_last;
    logic [7:0] sel_byte;

    assign load    = !r_valid || i_pop;
    assign take    = load && !i_job_empty;
    assign is_last = (r_idx == i_job.cnt - 2'd1);

    always_comb begin
        case (r_idx)
            2'd1:    sel_byte = i_job.byte1;
            2'd2:    sel_byte = i_job.byte2;
            default: sel_byte = i_job.byte0;
        endcase
    end

    always_comb begin
        n_idx    = r_idx;
        n_valid  = r_valid && !i_pop;
        o_job_rd = 1'b0;
        if (take) begin
            n_valid = 1'b1;
            if (is_last) begin
                // job done: advance the queue
                n_idx    = '0;
                o_job_rd = 1'b1;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte     <= sel_byte;
            r_run_last <= is_last;
            r_text_end <= is_last && i_job.text_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign o_empty        = !r_valid;
    assign o_out_byte     = r_byte;
    assign o_out_run_last = r_run_last;
    assign o_out_text_end = r_text_end;

endmodule
`default_nettype wire

// ----- rtl/uri_percent_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uri_percent_decoder
// Streaming percent-escape decoder: one raw byte in, zero to three bytes out.
// ----------------------------------------------------------------------------
// Path: the first result of an item passes through the job queue and then
//   the output register on its way to the output ports.
// Throughput: one input item per cycle into a JOB_DEPTH-deep job queue while
//   it is not full; the serializer sends one byte per cycle while the output
//   is empty or popped, and one item releases at most three bytes.
// Reset: synchronous, active low; clears escape phase, queue and output valid.
// ----------------------------------------------------------------------------
module uri_percent_decoder
    import upd_pkg::*;
#(
    parameter int JOB_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_out_run_last,
    output logic            o_out_text_end
);

    localparam int CW = $clog2(JOB_DEPTH + 1);

    t_job          f_job;
    logic          f_job_valid;
    t_phase        f_phase;
    t_job          q_job;
    logic          q_empty;
    logic          q_full;
    logic          q_rd;
    logic [CW-1:0] q_count;
    logic          accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    upd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_job       (f_job),
        .o_job_valid (f_job_valid),
        .o_phase     (f_phase)
    );

    upd_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (f_job_valid),
        .i_wr_job (f_job),
        .i_rd     (q_rd),
        .o_rd_job (q_job),
        .o_empty  (q_empty),
        .o_full   (q_full),
        .o_count  (q_count)
    );

    upd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (q_job),
        .i_job_empty    (q_empty),
        .o_job_rd       (q_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_out_run_last (o_out_run_last),
        .o_out_text_end (o_out_text_end)
    );

    // End of text leaves the front end idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_last |=> f_phase == PH_IDLE)
        else $error("phase not idle after last byte");

    // A last byte always produces a job.
    a_last_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_last |-> f_job_valid)
        else $error("last byte released no result");

    // End of text only on the last byte of a run.
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_text_end |-> o_out_run_last)
        else $error("text end without run last");

    // When the queue is full, its count equals the depth.
    a_q_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> q_count == CW'(JOB_DEPTH))
        else $error("queue full flag disagrees with count");

endmodule
`default_nettype wire
